FILE: rtl/prq_pkg.sv
// Shared types and codes for the process ready queue.
// No dependencies; used by every module in rtl/ except prq_ram.
package prq_pkg;

  localparam int NUM_PROCS_DEF = 16;
  localparam int ID_W          = 4;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;
  localparam int CMDQ_DEPTH    = 2;
  localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W    = $clog2(CMDQ_DEPTH + 1);

  // input opcodes
  localparam logic [OP_W-1:0] OP_ENQ    = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ    = 2'd1;
  localparam logic [OP_W-1:0] OP_REM    = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // result status
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_QUEUED    = 2'd3;

  // command kinds after decode
  localparam logic [1:0] KIND_ENQ = 2'd0;
  localparam logic [1:0] KIND_DEQ = 2'd1;
  localparam logic [1:0] KIND_REM = 2'd2;
  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]      kind;
    logic            id_ok;   // id below NUM_PROCS
    logic [ID_W-1:0] id;
  } prq_cmd_t;

endpackage

FILE: rtl/process_ready_queue_core.sv
// Process ready queue top level: front decoder/command queue feeding the
// execution back end. Depends on prq_pkg, prq_front, prq_back, prq_ram.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, opcode, proc_id   | request
//  out     | out_valid, out_stall, status, out_id, | response
//          | now_empty                             |
//
// Back end steps per transaction: enqueue, errors, unused opcode and popping
// the only entry finish in the idle state; dequeue or remove of the head
// otherwise go on to the pop state (one next-link RAM read); remove of any
// other entry walks the links from the head, then splices unless it is the tail.
// The front command queue holds two transactions, so input is taken while a
// result waits. Synchronous reset empties the queue and clears membership;
// the link RAM needs no clearing. out_stall holds the result register.
module process_ready_queue_core #(
  parameter int NUM_PROCS = prq_pkg::NUM_PROCS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [prq_pkg::OP_W-1:0] opcode,
  input  logic [prq_pkg::ID_W-1:0] proc_id,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [prq_pkg::ST_W-1:0] status,
  output logic [prq_pkg::ID_W-1:0] out_id,
  output logic                     now_empty
);
  import prq_pkg::*;

  logic     cmd_valid;
  logic     cmd_pop;
  prq_cmd_t cmd;

  prq_front #(
    .NUM_PROCS(NUM_PROCS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .proc_id  (proc_id),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  prq_back #(
    .NUM_PROCS(NUM_PROCS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .out_id   (out_id),
    .now_empty(now_empty)
  );

endmodule

FILE: rtl/prq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/prq_front.sv
// Front end: accepts input transactions, decodes them into commands and
// holds them in a short command queue. Depends on prq_pkg.
module prq_front #(
  parameter int NUM_PROCS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [prq_pkg::OP_W-1:0]       opcode,
  input  logic [prq_pkg::ID_W-1:0]       proc_id,
  output logic                           cmd_valid,
  output prq_pkg::prq_cmd_t              cmd,
  input  logic                           cmd_pop
);
  import prq_pkg::*;

  prq_cmd_t              entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;
  prq_cmd_t              decoded;
  logic                  push;

  always_comb begin
    decoded.id    = proc_id;
    decoded.id_ok = (32'(proc_id) < 32'(NUM_PROCS));
    unique case (opcode)
      OP_ENQ:  decoded.kind = KIND_ENQ;
      OP_DEQ:  decoded.kind = KIND_DEQ;
      OP_REM:  decoded.kind = KIND_REM;
      default: decoded.kind = KIND_NOP;
    endcase
  end

  assign in_stall  = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!push && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/prq_back.sv
// Back end: executes queue commands against head/tail, membership bits and
// the next-link RAM, and holds the result register. Depends on prq_pkg, prq_ram.
module prq_back #(
  parameter int NUM_PROCS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  input  prq_pkg::prq_cmd_t        cmd,
  output logic                     cmd_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [prq_pkg::ST_W-1:0] status,
  output logic [prq_pkg::ID_W-1:0] out_id,
  output logic                     now_empty
);
  import prq_pkg::*;

  localparam int AW = $clog2(NUM_PROCS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIX  = 2'd3;

  logic [1:0]           state, state_next;
  logic [ID_W-1:0]      head, head_next;
  logic [ID_W-1:0]      tail, tail_next;
  logic                 empty, empty_next;
  logic [NUM_PROCS-1:0] member, member_next;
  logic [ID_W-1:0]      cur, cur_next;
  logic [ID_W-1:0]      prev, prev_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ID_W-1:0]      ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ID_W-1:0]      ram_rdata;

  logic                 slot_free;
  logic                 do_pop;
  logic                 res_load;
  logic [ST_W-1:0]      res_status;
  logic [ID_W-1:0]      res_id;

  prq_ram #(
    .WIDTH(ID_W),
    .DEPTH(NUM_PROCS)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // a multi-cycle command only starts with the result slot free, so it is
  // still free when that command finishes
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty;
    member_next = member;
    cur_next    = cur;
    prev_next   = prev;
    cmd_pop     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = AW'(tail);
    ram_wdata   = cmd.id;
    ram_raddr   = AW'(head);
    do_pop      = 1'b0;
    res_load    = 1'b0;
    res_status  = ST_OK;
    res_id      = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop  = 1'b1;
          cur_next = cmd.id;
          unique case (cmd.kind)
            KIND_ENQ: begin
              res_load = 1'b1;
              if (!cmd.id_ok) begin
                res_status = ST_NOT_FOUND;
              end else if (member[AW'(cmd.id)]) begin
                res_status = ST_QUEUED;
              end else begin
                if (empty) begin
                  head_next = cmd.id;
                end else begin
                  ram_we = 1'b1;
                end
                tail_next                = cmd.id;
                member_next[AW'(cmd.id)] = 1'b1;
                empty_next               = 1'b0;
                res_id                   = cmd.id;
              end
            end
            KIND_DEQ: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                do_pop = 1'b1;
              end
            end
            KIND_REM: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else if (!cmd.id_ok || !member[AW'(cmd.id)]) begin
                res_load   = 1'b1;
                res_status = ST_NOT_FOUND;
              end else if (head == cmd.id) begin
                do_pop = 1'b1;
              end else begin
                // walk from the head looking for the predecessor
                prev_next  = head;
                state_next = S_WALK;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase

          if (do_pop) begin
            member_next[AW'(head)] = 1'b0;
            if (head == tail) begin
              head_next  = '0;
              tail_next  = '0;
              empty_next = 1'b1;
              res_load   = 1'b1;
              res_id     = head;
            end else begin
              cur_next   = head;
              state_next = S_POP;
            end
          end
        end
      end
      S_POP: begin
        head_next  = ram_rdata;
        res_load   = 1'b1;
        res_id     = cur;
        state_next = S_IDLE;
      end
      S_WALK: begin
        if (ram_rdata == cur) begin
          member_next[AW'(cur)] = 1'b0;
          if (cur == tail) begin
            tail_next  = prev;
            res_load   = 1'b1;
            res_id     = cur;
            state_next = S_IDLE;
          end else begin
            ram_raddr  = AW'(cur);
            state_next = S_FIX;
          end
        end else if (ram_rdata == tail) begin
          res_load   = 1'b1;
          res_status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          prev_next = ram_rdata;
          ram_raddr = AW'(ram_rdata);
        end
      end
      S_FIX: begin
        // splice predecessor to the removed entry's successor
        ram_we     = 1'b1;
        ram_waddr  = AW'(prev);
        ram_wdata  = ram_rdata;
        res_load   = 1'b1;
        res_id     = cur;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      empty     <= 1'b1;
      member    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      empty  <= empty_next;
      member <= member_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    prev <= prev_next;
    if (res_load) begin
      status    <= res_status;
      out_id    <= res_id;
      now_empty <= empty_next;
    end
  end

endmodule

FILE: tb/process_ready_queue_core_test.sv
// Testbench for process_ready_queue_core: directed and random enqueue, dequeue
// and remove traffic, scored against a linked-list queue tracker.
// Depends on rtl/prq_pkg.sv and the process_ready_queue_core RTL.
module process_ready_queue_core_test;
  import prq_pkg::*;

  localparam int NPROC       = NUM_PROCS_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_ITEMS  = 650;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] id;
    logic            empty;
  } queue_result_t;

  // Tracks head, tail, links and membership, and keeps the results still owed.
  class ready_queue_tracker;
    logic [ID_W-1:0]      head;
    logic [ID_W-1:0]      tail;
    logic                 empty;
    logic [NPROC*ID_W-1:0] links;
    logic [NPROC-1:0]     member;
    queue_result_t        owed[$];
    int                   errors;

    function new();
      head   = '0;
      tail   = '0;
      empty  = 1'b1;
      links  = '0;
      member = '0;
      errors = 0;
    endfunction

    function logic [ID_W-1:0] pop_head();
      logic [ID_W-1:0] got;
      got = head;
      member[got] = 1'b0;
      if (head == tail) begin
        head  = '0;
        tail  = '0;
        empty = 1'b1;
      end else begin
        head = links[head*ID_W +: ID_W];
      end
      return got;
    endfunction

    // Predicts the result of one accepted transaction and updates the state.
    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] pid);
      queue_result_t   r;
      logic [ID_W-1:0] prev;
      logic [ID_W-1:0] nxt;
      int              steps;
      bit              found;
      r.status = ST_OK;
      r.id     = '0;
      case (op)
        OP_ENQ: begin
          if (int'(pid) >= NPROC) begin
            r.status = ST_NOT_FOUND;
          end else if (member[pid]) begin
            r.status = ST_QUEUED;
          end else begin
            if (empty) head = pid;
            else links[tail*ID_W +: ID_W] = pid;
            tail = pid;
            links[pid*ID_W +: ID_W] = '0;
            member[pid] = 1'b1;
            empty = 1'b0;
            r.id = pid;
          end
        end
        OP_DEQ: begin
          if (empty) r.status = ST_EMPTY;
          else r.id = pop_head();
        end
        OP_REM: begin
          if (empty) begin
            r.status = ST_EMPTY;
          end else if (int'(pid) >= NPROC || !member[pid]) begin
            r.status = ST_NOT_FOUND;
          end else if (head == pid) begin
            r.id = pop_head();
          end else begin
            prev  = head;
            steps = 0;
            found = 0;
            while (!found && prev != tail && steps < NPROC) begin
              nxt = links[prev*ID_W +: ID_W];
              if (nxt == pid) begin
                found = 1;
              end else begin
                prev = nxt;
                steps++;
              end
            end
            if (!found) begin
              r.status = ST_NOT_FOUND;
            end else begin
              if (pid == tail) tail = prev;
              else links[prev*ID_W +: ID_W] = links[pid*ID_W +: ID_W];
              links[pid*ID_W +: ID_W] = '0;
              member[pid] = 1'b0;
              r.id = pid;
            end
          end
        end
        default: ;
      endcase
      r.empty = empty;
      owed.push_back(r);
    endfunction

    function void check_result(logic [ST_W-1:0] st, logic [ID_W-1:0] id, logic emp);
      queue_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result status %0d id %0d empty %0d", $time, st, id, emp);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (st !== e.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (id !== e.id) begin
        $display("%0t: out_id mismatch expected %0d actual %0d", $time, e.id, id);
        errors++;
      end
      if (emp !== e.empty) begin
        $display("%0t: now_empty mismatch expected %0d actual %0d", $time, e.empty, emp);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function int queued_count();
      int n;
      n = 0;
      for (int i = 0; i < NPROC; i++) n += member[i];
      return n;
    endfunction

    // Random id whose membership equals want; falls back to any id.
    function logic [ID_W-1:0] pick_id(bit want);
      int n;
      int k;
      n = 0;
      for (int i = 0; i < NPROC; i++) if (member[i] == want) n++;
      if (n == 0) return ID_W'($urandom_range(15));
      k = $urandom_range(n - 1);
      for (int i = 0; i < NPROC; i++) begin
        if (member[i] == want) begin
          if (k == 0) return ID_W'(i);
          k--;
        end
      end
      return '0;
    endfunction
  endclass

  logic            clk;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [OP_W-1:0] opcode = OP_ENQ;
  logic [ID_W-1:0] proc_id = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [ST_W-1:0] status;
  logic [ID_W-1:0] out_id;
  logic            now_empty;

  ready_queue_tracker tracker = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycle_cnt = 0;

  process_ready_queue_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .proc_id(proc_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_id(out_id), .now_empty(now_empty)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Receiver side: random stall, or a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(status, out_id, now_empty);
  end

  // Offer one transaction and return at the edge that accepts it.
  task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] pid);
    in_valid <= 1'b1;
    opcode   <= op;
    proc_id  <= pid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(op, pid);
  endtask

  // Each cycle the sender could offer, it idles with send_idle_pct odds.
  task automatic maybe_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random();
    int r;
    int cnt;
    int enq_w;
    cnt   = tracker.queued_count();
    enq_w = (cnt < 4) ? 65 : (cnt > 12) ? 20 : 45;
    r     = $urandom_range(99);
    if (r < enq_w) begin
      send_item(OP_ENQ, ($urandom_range(99) < 80) ? tracker.pick_id(1'b0)
                                                  : ID_W'($urandom_range(15)));
    end else begin
      r = $urandom_range(99);
      if (r < 40) send_item(OP_DEQ, ID_W'($urandom_range(15)));
      else if (r < 92) send_item(OP_REM, ($urandom_range(99) < 80) ? tracker.pick_id(1'b1)
                                                                  : ID_W'($urandom_range(15)));
      else send_item(OP_UNUSED, ID_W'($urandom_range(15)));
    end
  endtask

  task automatic run_directed();
    send_item(OP_DEQ, 4'd0);      // dequeue on empty
    send_item(OP_REM, 4'd5);      // remove on empty
    send_item(OP_UNUSED, 4'd9);
    send_item(OP_ENQ, 4'd0);
    send_item(OP_ENQ, 4'd0);      // double enqueue
    send_item(OP_ENQ, 4'd15);
    send_item(OP_ENQ, 4'd7);
    send_item(OP_ENQ, 4'd3);
    send_item(OP_REM, 4'd9);      // not queued
    send_item(OP_REM, 4'd3);      // tail moves back
    send_item(OP_REM, 4'd15);     // mid-list splice
    send_item(OP_REM, 4'd0);      // head
    send_item(OP_DEQ, 4'd15);     // last entry
    send_item(OP_ENQ, 4'd10);
    send_item(OP_ENQ, 4'd5);
    send_item(OP_ENQ, 4'd15);
    send_item(OP_UNUSED, 4'd6);
    send_item(OP_DEQ, 4'd0);
    send_item(OP_DEQ, 4'd0);
    send_item(OP_DEQ, 4'd0);
    send_item(OP_DEQ, 4'd0);
    send_item(OP_ENQ, 4'd12);
    send_item(OP_REM, 4'd12);     // head that is also the tail
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 65 : 0;
      recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 20 : 0;
      for (int n = 0; n < RAND_ITEMS / 3; n++) begin
        if (phase == 1 && n == 100) drain();
        if (phase == 2 && n == 50) hold_req = 1'b1;  // sender keeps offering
        maybe_gap();
        send_random();
      end
      drain();
    end
    repeat (30) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/prq_pkg.sv
rtl/prq_ram.sv
rtl/prq_front.sv
rtl/prq_back.sv
rtl/process_ready_queue_core.sv
tb/process_ready_queue_core_test.sv
